// ===== design/mfq_pkg.sv =====
// Shared request/response types and fixed field widths for the feedback-queue scheduler.
`timescale 1ns / 1ps

package mfq_pkg;

    // Fixed field widths of the request and response
    localparam int ID_W       = 6;
    localparam int ID_COUNT   = 1 << ID_W;
    localparam int IN_LVL_W   = 3;
    localparam int SLICE_W    = 16;
    localparam int TOTAL_W    = 10;

    // Action codes
    localparam logic ACT_ENQUEUE  = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    typedef struct packed {
        logic                action;
        logic [ID_W-1:0]     thread_id;
        logic [IN_LVL_W-1:0] initial_level;
    } mfq_req_t;

    typedef struct packed {
        logic                granted;
        logic [ID_W-1:0]     chosen_thread;
        logic [IN_LVL_W-1:0] chosen_level;
        logic [SLICE_W-1:0]  slice_ticks;
        logic                dropped;
        logic [TOTAL_W-1:0]  total_waiting;
    } mfq_rsp_t;

    // Operation handed to the level queues for the request that advances
    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] tid;
    } mfq_qop_t;

    // Queue status seen by the control path
    typedef struct packed {
        logic any_waiting;
        logic push_full;
    } mfq_qstat_t;

    // Thread table update
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] tid;
    } mfq_twr_t;

endpackage

// ===== design/multilevel_feedback_scheduler_top.sv =====
// Top level of the multilevel feedback queue scheduler: request stage, control, response register.
// Flow: an accepted request waits in the request register until the response register is free to take it.
// Throughput: one request per cycle; the request register and the response register
// hold one request each, and a stalled response holds the request stage.
// Reset: clears queue counts, heads, seen flags and the waiting total; sets the time slice to 3.
// The queue store and recorded levels need no clearing, so requests are taken right after reset.
`timescale 1ns / 1ps

module multilevel_feedback_scheduler_top
    import mfq_pkg::*;
#(
    parameter int NUM_LEVELS  = 8,
    parameter int MAX_THREADS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SLICE_W-1:0] cfg_wdata,
    input  logic               req_valid,
    output logic               req_stall,
    input  mfq_req_t           req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output mfq_rsp_t           rsp
);

    localparam int LVL_W = $clog2(NUM_LEVELS);
    localparam int TOT_W = $clog2(NUM_LEVELS * MAX_THREADS + 1);
    localparam logic [LVL_W-1:0] LAST_LV = LVL_W'(NUM_LEVELS - 1);

    logic [SLICE_W-1:0] slice_reg;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    mfq_req_t           s1_req_reg;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               rsp_granted_reg;
    logic [LVL_W-1:0]   rsp_lv_reg;
    logic [SLICE_W-1:0] rsp_slice_reg;
    logic               rsp_dropped_reg;

    logic               accept;
    logic               s1_adv;
    logic [ID_W-1:0]    tid_tab [ID_COUNT];
    logic [ID_W-1:0]    req_tid;
    logic               seen;
    logic [LVL_W-1:0]   known_lv;
    logic [LVL_W-1:0]   enq_lv;
    logic               is_enq;
    mfq_qop_t           qop;
    mfq_qstat_t         qstat;
    mfq_twr_t           twr;
    logic [LVL_W-1:0]   pop_lv;
    logic [ID_W-1:0]    pop_tid;
    logic [TOT_W-1:0]   total;
    logic               granted;

    // Fold thread ids into the thread range
    for (genvar g = 0; g < ID_COUNT; g++)
    begin : g_tid_tab
        assign tid_tab[g] = ID_W'(g % MAX_THREADS);
    end

    assign req_tid = tid_tab[req.thread_id];

    // Handshake: advance the request stage when the response register frees up
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_adv;
    assign accept    = req_valid && !req_stall;

    // Hold the time slice register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= SLICE_W'(3);
        end
        else if (cfg_we)
        begin
            slice_reg <= cfg_wdata;
        end
    end

    // Request stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= {req.action, req_tid, req.initial_level};
        end
    end

    // Target level: demote a known thread, clamp a new one
    always_comb
    begin
        if (seen)
        begin
            enq_lv = (known_lv == LAST_LV) ? LAST_LV : known_lv + LVL_W'(1);
        end
        else if (32'(s1_req_reg.initial_level) >= 32'(NUM_LEVELS))
        begin
            enq_lv = LAST_LV;
        end
        else
        begin
            enq_lv = LVL_W'(s1_req_reg.initial_level);
        end
    end

    assign is_enq   = (s1_req_reg.action == ACT_ENQUEUE);
    assign qop.push = s1_adv && is_enq;
    assign qop.pop  = s1_adv && (s1_req_reg.action == ACT_DISPATCH);
    assign qop.tid  = s1_req_reg.thread_id;
    assign twr.en   = s1_adv && is_enq && !qstat.push_full;
    assign twr.tid  = s1_req_reg.thread_id;
    assign granted  = !is_enq && qstat.any_waiting;

    mfq_thread_table #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) u_thread_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_tid   (req_tid),
        .look_tid (s1_req_reg.thread_id),
        .wr       (twr),
        .wr_lv    (enq_lv),
        .seen     (seen),
        .level    (known_lv)
    );

    mfq_level_queues #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) u_level_queues (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (qop),
        .push_lv (enq_lv),
        .stat    (qstat),
        .pop_lv  (pop_lv),
        .pop_tid (pop_tid),
        .total   (total)
    );

    // Response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (s1_adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            rsp_granted_reg <= granted;
            rsp_lv_reg      <= granted ? pop_lv : '0;
            rsp_slice_reg   <= granted ? slice_reg : '0;
            rsp_dropped_reg <= is_enq && qstat.push_full;
        end
    end

    // Drive the response; thread id and total come from registers that load on the same edge
    always_comb
    begin
        rsp.granted       = rsp_granted_reg;
        rsp.chosen_thread = rsp_granted_reg ? pop_tid : '0;
        rsp.chosen_level  = IN_LVL_W'(rsp_lv_reg);
        rsp.slice_ticks   = rsp_slice_reg;
        rsp.dropped       = rsp_dropped_reg;
        rsp.total_waiting = TOTAL_W'(total);
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== design/mfq_thread_table.sv =====
// Per-thread seen flags and recorded levels, with bypass of the newest update.
`timescale 1ns / 1ps

module mfq_thread_table
    import mfq_pkg::*;
#(
    parameter int NUM_LEVELS  = 8,
    parameter int MAX_THREADS = 64,
    localparam int LVL_W      = $clog2(NUM_LEVELS),
    localparam int TBL_DEPTH  = (MAX_THREADS < ID_COUNT) ? MAX_THREADS : ID_COUNT,
    localparam int TBL_W      = $clog2(TBL_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [ID_W-1:0]  rd_tid,
    input  logic [ID_W-1:0]  look_tid,
    input  mfq_twr_t         wr,
    input  logic [LVL_W-1:0] wr_lv,
    output logic             seen,
    output logic [LVL_W-1:0] level
);

    logic [TBL_DEPTH-1:0] seen_reg;
    logic [LVL_W-1:0]     lvl_mem [TBL_DEPTH];
    logic [LVL_W-1:0]     lvl_rd_reg;
    logic                 fwd_hit_reg;
    logic [LVL_W-1:0]     fwd_lv_reg;
    logic [TBL_W-1:0]     rd_idx;
    logic [TBL_W-1:0]     look_idx;
    logic [TBL_W-1:0]     wr_idx;

    assign rd_idx   = TBL_W'(rd_tid);
    assign look_idx = TBL_W'(look_tid);
    assign wr_idx   = TBL_W'(wr.tid);

    // Mark threads seen on a successful enqueue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (wr.en)
        begin
            seen_reg[wr_idx] <= 1'b1;
        end
    end

    // Level memory: write on update, registered read on request accept
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            lvl_mem[wr_idx] <= wr_lv;
        end
        if (rd_en)
        begin
            lvl_rd_reg <= lvl_mem[rd_idx];
        end
    end

    // Capture an update landing on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr.en && (wr_idx == rd_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_lv_reg <= wr_lv;
        end
    end

    assign seen  = seen_reg[look_idx];
    assign level = fwd_hit_reg ? fwd_lv_reg : lvl_rd_reg;

endmodule

// ===== design/mfq_level_queues.sv =====
// Per-level FIFOs in one store memory, with head/count tracking and priority pick.
`timescale 1ns / 1ps

module mfq_level_queues
    import mfq_pkg::*;
#(
    parameter int NUM_LEVELS  = 8,
    parameter int MAX_THREADS = 64,
    localparam int LVL_W      = $clog2(NUM_LEVELS),
    localparam int TOT_W      = $clog2(NUM_LEVELS * MAX_THREADS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mfq_qop_t         op,
    input  logic [LVL_W-1:0] push_lv,
    output mfq_qstat_t       stat,
    output logic [LVL_W-1:0] pop_lv,
    output logic [ID_W-1:0]  pop_tid,
    output logic [TOT_W-1:0] total
);

    localparam int PTR_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    logic [CNT_W-1:0]  cnt_reg   [NUM_LEVELS];
    logic [CNT_W-1:0]  cnt_next  [NUM_LEVELS];
    logic [PTR_W-1:0]  head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]  head_next [NUM_LEVELS];
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;
    logic [ID_W-1:0]   store_mem [NUM_LEVELS][MAX_THREADS];
    logic [ID_W-1:0]   rd_reg;

    logic [NUM_LEVELS-1:0] nonempty;
    logic                  any_waiting;
    logic                  push_full;
    logic                  do_push;
    logic                  do_pop;
    logic [PTR_W:0]        tail_sum;
    logic [PTR_W-1:0]      tail;
    logic [PTR_W-1:0]      pop_head;
    logic [PTR_W-1:0]      head_inc;

    // Find the highest-priority nonempty level
    always_comb
    begin
        pop_lv = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            nonempty[l] = (cnt_reg[l] != '0);
        end
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (nonempty[l])
            begin
                pop_lv = LVL_W'(l);
            end
        end
    end

    assign any_waiting = |nonempty;
    assign push_full   = (cnt_reg[push_lv] == CNT_W'(MAX_THREADS));
    assign do_push     = op.push && !push_full;
    assign do_pop      = op.pop && any_waiting;

    // Tail slot: head plus count, wrapped once
    assign tail_sum = (PTR_W + 1)'(head_reg[push_lv]) + (PTR_W + 1)'(cnt_reg[push_lv]);
    assign tail     = (tail_sum >= (PTR_W + 1)'(MAX_THREADS))
                    ? PTR_W'(tail_sum - (PTR_W + 1)'(MAX_THREADS))
                    : PTR_W'(tail_sum);

    // Advance the popped head with wrap
    assign pop_head = head_reg[pop_lv];
    assign head_inc = ((PTR_W + 1)'(pop_head) + (PTR_W + 1)'(1) == (PTR_W + 1)'(MAX_THREADS))
                    ? '0 : pop_head + PTR_W'(1);

    always_comb
    begin
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        total_next = total_reg;
        if (do_push)
        begin
            cnt_next[push_lv] = cnt_reg[push_lv] + CNT_W'(1);
            total_next        = total_reg + TOT_W'(1);
        end
        if (do_pop)
        begin
            cnt_next[pop_lv]  = cnt_reg[pop_lv] - CNT_W'(1);
            head_next[pop_lv] = head_inc;
            total_next        = total_reg - TOT_W'(1);
        end
    end

    // Hold counts, heads and the waiting total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                cnt_reg[l]  <= '0;
                head_reg[l] <= '0;
            end
            total_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            total_reg <= total_next;
        end
    end

    // Store memory: write the tail on push, registered read of the head on pop
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_mem[push_lv][tail] <= op.tid;
        end
        if (op.pop)
        begin
            rd_reg <= store_mem[pop_lv][pop_head];
        end
    end

    assign stat.any_waiting = any_waiting;
    assign stat.push_full   = push_full;
    assign pop_tid          = rd_reg;
    assign total            = total_reg;

endmodule
